/* hdl/gwm_pkg.sv */
// Shared constants, types and codes for the glob line matcher.
package gwm_pkg;

	localparam int PAT_BYTES = 32;
	localparam int LEN_W = $clog2(PAT_BYTES + 1);
	localparam int LINE_W = 16;
	localparam int CELLS = PAT_BYTES + 1;

	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_LBR = 8'h5B;
	localparam logic [7:0] CH_RBR = 8'h5D;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_DASH = 8'h2D;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_TEXT = 2'd2;
	localparam logic [1:0] ACT_EOL = 2'd3;

	// Parse and match state handed from one cell to the next.
	typedef struct packed {
		logic       reach;
		logic       setn;
		logic       in_cls;
		logic       first;
		logic       cact;
		logic       chit;
		logic       cneg;
		logic [1:0] skip;
	} carry_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic sel;
		logic is_end;
		logic fin;
		logic below;
		logic fresh;
		logic start;
		logic v0;
		logic v1;
		logic v2;
	} cell_ctl_t;

endpackage

/* hdl/gwm_cell.sv */
// One pattern position: stored byte, active bit and the local parse step.
module gwm_cell (
	input  logic              clk,
	input  logic              pat_we,
	input  logic [7:0]        pat_wd,
	output logic [7:0]        pat,
	input  gwm_pkg::cell_ctl_t ctl,
	input  logic [7:0]        c,
	input  logic [7:0]        pat_n1,
	input  logic [7:0]        pat_n2,
	input  gwm_pkg::carry_t   ci,
	output gwm_pkg::carry_t   co,
	output logic              match
);

	logic [7:0] pat_q;
	logic       act_q;
	logic       nxt_q;
	logic       ract;
	logic       nxt;

	assign pat = pat_q;
	assign ract = (ctl.fresh ? ctl.start : act_q) | ci.reach;
	assign match = ract;

	always_comb begin
		co = ci;
		co.reach = 1'b0;
		co.setn = 1'b0;
		nxt = ci.setn;
		if (ctl.is_end) begin
			nxt = ci.setn | (ci.in_cls & ci.cact & (ci.chit ^ ci.cneg));
		end else if (!ci.in_cls) begin
			if (pat_q == gwm_pkg::CH_STAR) begin
				co.reach = ract;
				nxt = ci.setn | ract;
			end else if (pat_q == gwm_pkg::CH_QUEST) begin
				co.setn = ract;
			end else if (pat_q == gwm_pkg::CH_LBR) begin
				co.in_cls = 1'b1;
				co.first = 1'b1;
				co.cact = ract;
				co.chit = 1'b0;
				co.cneg = 1'b0;
				co.skip = 2'd0;
			end else begin
				co.setn = ract & (c == pat_q);
			end
		end else if (ci.skip != 2'd0) begin
			co.skip = ci.skip - 2'd1;
		end else if (ci.first && pat_q == gwm_pkg::CH_BANG) begin
			co.cneg = 1'b1;
			co.first = 1'b0;
		end else if (pat_q == gwm_pkg::CH_RBR) begin
			co.in_cls = 1'b0;
			co.first = 1'b0;
			co.setn = ci.cact & (ci.chit ^ ci.cneg);
		end else begin
			co.first = 1'b0;
			if (ctl.v1 && ctl.v2 && pat_n1 == gwm_pkg::CH_DASH && pat_n2 != gwm_pkg::CH_RBR) begin
				co.chit = ci.chit | (c >= pat_q && c <= pat_n2);
				co.skip = 2'd2;
			end else begin
				co.chit = ci.chit | (c == pat_q);
			end
		end
		if (!ctl.v0 && !ctl.is_end) begin
			nxt = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_q <= pat_wd;
		end
		if (ctl.sel) begin
			nxt_q <= nxt;
		end
		if (ctl.fin) begin
			act_q <= ctl.sel ? nxt : (ctl.below ? nxt_q : 1'b0);
		end
	end

endmodule

/* hdl/glob_wildcard_line_matcher.sv */
// Glob line matcher top level: command decode, sweep sequencer and result register.
// A clear or pattern append updates the pattern state directly; a text byte or an end
// of line starts one left-to-right sweep of the cell row, from cell 0 to the pattern length.
// A line result loads an output register when its sweep ends and waits there;
// while that register is full and out_stall is high, the result holds and stalls input.
// Reset clears the pattern length, line count, overflow flag and the active set to
// start only; pattern bytes are undefined until written.
module glob_wildcard_line_matcher (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 action,
	input  logic [7:0]                 data_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       line_matched,
	output logic [gwm_pkg::LINE_W-1:0] line_number,
	output logic                       pattern_overflow
);

	typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_HOLD} state_t;

	state_t                     state_q;
	logic [gwm_pkg::LEN_W-1:0]  len_q;
	logic [gwm_pkg::LEN_W-1:0]  pos_q;
	logic [gwm_pkg::LINE_W-1:0] line_q;
	logic                       ovf_q;
	logic                       fresh_q;
	logic                       eol_q;
	logic [7:0]                 c_q;
	logic                       match_q;
	logic                       out_valid_q;
	logic                       line_matched_q;
	logic [gwm_pkg::LINE_W-1:0] line_number_q;
	logic                       ovf_out_q;

	gwm_pkg::carry_t    car_q [gwm_pkg::CELLS];
	gwm_pkg::carry_t    co_w [gwm_pkg::CELLS];
	gwm_pkg::cell_ctl_t ctl_w [gwm_pkg::CELLS];
	logic [7:0]         pat_a [gwm_pkg::CELLS + 2];
	logic [gwm_pkg::CELLS-1:0] match_w;
	logic [gwm_pkg::CELLS-1:0] sel_w;

	logic in_acc;
	logic done;
	logic fin_text;
	logic out_free;
	logic match_now;
	logic app_we;
	logic out_load;
	logic [gwm_pkg::LINE_W-1:0] line_inc;

	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign done = (state_q == S_SWEEP) && (pos_q == len_q);
	assign fin_text = done && !eol_q;
	assign out_free = !out_valid_q || !out_stall;
	assign match_now = |(match_w & sel_w);
	assign app_we = in_acc && action == gwm_pkg::ACT_APPEND;

	// A line result loads the output register when its sweep ends or while it waits.
	assign out_load = ((done && eol_q) || (state_q == S_HOLD)) && out_free;
	assign line_inc = (line_q != '1) ? line_q + 1'b1 : line_q;

	assign out_valid = out_valid_q;
	assign line_matched = line_matched_q;
	assign line_number = line_number_q;
	assign pattern_overflow = ovf_out_q;

	assign pat_a[gwm_pkg::CELLS] = 8'h00;
	assign pat_a[gwm_pkg::CELLS + 1] = 8'h00;

	// The row of cells: each one hands its parse state to the next through car_q.
	for (genvar j = 0; j < gwm_pkg::CELLS; j++) begin : g_cell
		assign sel_w[j] = (state_q == S_SWEEP) && (pos_q == gwm_pkg::LEN_W'(j));
		assign ctl_w[j].sel = sel_w[j];
		assign ctl_w[j].is_end = (len_q == gwm_pkg::LEN_W'(j));
		assign ctl_w[j].fin = fin_text;
		assign ctl_w[j].below = (j < int'(pos_q));
		assign ctl_w[j].fresh = fresh_q;
		assign ctl_w[j].start = (j == 0);
		assign ctl_w[j].v0 = (j < int'(len_q));
		assign ctl_w[j].v1 = (j + 1 < int'(len_q));
		assign ctl_w[j].v2 = (j + 2 < int'(len_q));

		gwm_cell u_cell (
			.clk    (clk),
			.pat_we (app_we && (len_q == gwm_pkg::LEN_W'(j)) && (j < gwm_pkg::PAT_BYTES)),
			.pat_wd (data_byte),
			.pat    (pat_a[j]),
			.ctl    (ctl_w[j]),
			.c      (c_q),
			.pat_n1 (pat_a[j + 1]),
			.pat_n2 (pat_a[j + 2]),
			.ci     (car_q[j]),
			.co     (co_w[j]),
			.match  (match_w[j])
		);
	end

	// Carry links between neighboring cells.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			car_q[0] <= '0;
		end
		for (int j = 0; j < gwm_pkg::CELLS - 1; j++) begin
			if (sel_w[j]) begin
				car_q[j + 1] <= co_w[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			c_q <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q <= '0;
			pos_q <= '0;
			line_q <= '0;
			ovf_q <= 1'b0;
			fresh_q <= 1'b1;
			eol_q <= 1'b0;
			match_q <= 1'b0;
			out_valid_q <= 1'b0;
			line_matched_q <= 1'b0;
			line_number_q <= '0;
			ovf_out_q <= 1'b0;
		end else begin
			out_valid_q <= out_load | (out_valid_q & out_stall);
			if (out_load) begin
				line_number_q <= line_inc;
				ovf_out_q <= ovf_q;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (action)
							gwm_pkg::ACT_CLEAR: begin
								len_q <= '0;
								line_q <= '0;
								ovf_q <= 1'b0;
								fresh_q <= 1'b1;
							end
							gwm_pkg::ACT_APPEND: begin
								if (int'(len_q) < gwm_pkg::PAT_BYTES) begin
									len_q <= len_q + 1'b1;
								end else begin
									ovf_q <= 1'b1;
								end
								fresh_q <= 1'b1;
							end
							gwm_pkg::ACT_TEXT, gwm_pkg::ACT_EOL: begin
								eol_q <= (action == gwm_pkg::ACT_EOL);
								pos_q <= '0;
								state_q <= S_SWEEP;
							end
							default: begin
							end
						endcase
					end
				end
				S_SWEEP: begin
					if (done) begin
						if (!eol_q) begin
							fresh_q <= 1'b0;
							state_q <= S_IDLE;
						end else if (out_free) begin
							line_matched_q <= match_now;
							line_q <= line_inc;
							fresh_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							match_q <= match_now;
							state_q <= S_HOLD;
						end
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						line_matched_q <= match_q;
						line_q <= line_inc;
						fresh_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
